@@ rtl/cmta_pkg.sv @@
// Shared types and constants for the cube map texel address pipeline.
// No dependencies; the RTL files refer to this package by scoped names, the testbench imports it.
package cmta_pkg;

	localparam int MAX_FACE_WIDTH_DEF = 1024;
	localparam int COMPONENT_BITS_DEF = 16;

	localparam int FACE_WIDTH_BITS  = 11;
	localparam int FACE_BITS        = 3;
	localparam int TEXEL_INDEX_BITS = 23;

	localparam logic [FACE_WIDTH_BITS-1:0] FACE_WIDTH_RESET = 11'd1024;

	// register stages before and after the divider lanes
	localparam int FRONT_STAGES = 3;
	localparam int BACK_STAGES  = 4;

	typedef enum logic [FACE_BITS-1:0] {
		FACE_POS_X = 3'd0,
		FACE_NEG_X = 3'd1,
		FACE_POS_Y = 3'd2,
		FACE_NEG_Y = 3'd3,
		FACE_POS_Z = 3'd4,
		FACE_NEG_Z = 3'd5
	} face_t;

	typedef struct packed {
		face_t face;
		logic  degen;
	} face_info_t;

endpackage

@@ rtl/cmta_face_sel.sv @@
// Front stages: major axis pick, face axes and division operands.
// Depends on cmta_pkg.
module cmta_face_sel #(
	parameter int CB = cmta_pkg::COMPONENT_BITS_DEF,
	parameter int WB = 11
) (
	input  logic                     clk,
	input  logic [2:0]               en,
	input  logic signed [CB-1:0]     dir_x,
	input  logic signed [CB-1:0]     dir_y,
	input  logic signed [CB-1:0]     dir_z,
	input  logic [WB-1:0]            w,
	output logic [CB+WB:0]           num_col,
	output logic [CB+WB:0]           num_row,
	output logic [CB:0]              den,
	output cmta_pkg::face_info_t     info
);

	localparam int RW = CB + 1 + WB;

	logic [CB-1:0]        ax, ay, az;
	logic signed [CB:0]   xe, ye, ze;
	logic signed [CB:0]   sc_d, tc_d;
	logic [CB-1:0]        ma_d;
	cmta_pkg::face_info_t info_d;

	logic signed [CB:0]   sc_s1, tc_s1;
	logic [CB-1:0]        ma_s1;
	cmta_pkg::face_info_t info_s1;

	logic signed [CB+1:0] ssum, tsum;
	logic [CB:0]          s_s2, t_s2, den_s2;
	cmta_pkg::face_info_t info_s2;

	logic [RW-1:0]        num_col_s3, num_row_s3;
	logic [CB:0]          den_s3;
	cmta_pkg::face_info_t info_s3;

	assign xe = {dir_x[CB-1], dir_x};
	assign ye = {dir_y[CB-1], dir_y};
	assign ze = {dir_z[CB-1], dir_z};
	assign ax = dir_x[CB-1] ? $unsigned(-dir_x) : $unsigned(dir_x);
	assign ay = dir_y[CB-1] ? $unsigned(-dir_y) : $unsigned(dir_y);
	assign az = dir_z[CB-1] ? $unsigned(-dir_z) : $unsigned(dir_z);

	always_comb begin
		info_d.degen = (ax == '0) && (ay == '0) && (az == '0);
		priority if (ax >= ay && ax >= az) begin
			tc_d = -ye;
			ma_d = ax;
			if (!dir_x[CB-1]) begin
				sc_d = -ze;
				info_d.face = cmta_pkg::FACE_POS_X;
			end else begin
				sc_d = ze;
				info_d.face = cmta_pkg::FACE_NEG_X;
			end
		end else if (ay >= az) begin
			sc_d = xe;
			ma_d = ay;
			if (!dir_y[CB-1]) begin
				tc_d = ze;
				info_d.face = cmta_pkg::FACE_POS_Y;
			end else begin
				tc_d = -ze;
				info_d.face = cmta_pkg::FACE_NEG_Y;
			end
		end else begin
			tc_d = -ye;
			ma_d = az;
			if (!dir_z[CB-1]) begin
				sc_d = xe;
				info_d.face = cmta_pkg::FACE_POS_Z;
			end else begin
				sc_d = -xe;
				info_d.face = cmta_pkg::FACE_NEG_Z;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			sc_s1   <= sc_d;
			tc_s1   <= tc_d;
			ma_s1   <= ma_d;
			info_s1 <= info_d;
		end
	end

	// c + ma lies in 0 .. 2*ma, so it fits CB+1 unsigned bits
	assign ssum = {sc_s1[CB], sc_s1} + {2'b00, ma_s1};
	assign tsum = {tc_s1[CB], tc_s1} + {2'b00, ma_s1};

	always_ff @(posedge clk) begin
		if (en[1]) begin
			s_s2    <= ssum[CB:0];
			t_s2    <= tsum[CB:0];
			den_s2  <= {ma_s1, 1'b0};
			info_s2 <= info_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			num_col_s3 <= RW'(s_s2) * RW'(w);
			num_row_s3 <= RW'(t_s2) * RW'(w);
			den_s3     <= den_s2;
			info_s3    <= info_s2;
		end
	end

	assign num_col = num_col_s3;
	assign num_row = num_row_s3;
	assign den     = den_s3;
	assign info    = info_s3;

endmodule

@@ rtl/cmta_div.sv @@
// Pipelined restoring divider lane, one quotient bit per stage.
// Depends on cmta_pkg for its default component width.
module cmta_div #(
	parameter int CB = cmta_pkg::COMPONENT_BITS_DEF,
	parameter int QB = 11
) (
	input  logic              clk,
	input  logic [QB-1:0]     en,
	input  logic [CB+QB:0]    num,
	input  logic [CB:0]       den,
	output logic [QB-1:0]     quo
);

	localparam int RW = CB + 1 + QB;

	logic [RW-1:0] rem_s [QB];
	logic [QB-1:0] quo_s [QB];
	logic [CB:0]   den_s [QB];

	for (genvar i = 0; i < QB; i++) begin : g_step
		logic [RW-1:0] rem_in;
		logic [RW-1:0] trial;
		logic [QB-1:0] quo_in;
		logic [CB:0]   den_in;
		logic [QB:0]   quo_sh;
		logic          ge;

		if (i == 0) begin : g_first
			assign rem_in = num;
			assign quo_in = '0;
			assign den_in = den;
		end else begin : g_next
			assign rem_in = rem_s[i-1];
			assign quo_in = quo_s[i-1];
			assign den_in = den_s[i-1];
		end

		// quotient is below 2**QB, so the shifted divisor never loses bits
		assign trial  = RW'(den_in) << (QB - 1 - i);
		assign ge     = rem_in >= trial;
		assign quo_sh = {quo_in, ge};

		always_ff @(posedge clk) begin
			if (en[i]) begin
				rem_s[i] <= ge ? rem_in - trial : rem_in;
				quo_s[i] <= quo_sh[QB-1:0];
				den_s[i] <= den_in;
			end
		end
	end

	assign quo = quo_s[QB-1];

endmodule

@@ rtl/cmta_addr.sv @@
// Back stages: clamp to the face, zero degenerate beats, linear texel address.
// Depends on cmta_pkg.
module cmta_addr #(
	parameter int WB = 11,
	parameter int CW = 10
) (
	input  logic                                     clk,
	input  logic [3:0]                               en,
	input  logic [WB-1:0]                            w,
	input  logic [WB-1:0]                            quo_col,
	input  logic [WB-1:0]                            quo_row,
	input  cmta_pkg::face_info_t                     info,
	output logic [cmta_pkg::FACE_BITS-1:0]           face,
	output logic [CW-1:0]                            col,
	output logic [CW-1:0]                            row,
	output logic [cmta_pkg::TEXEL_INDEX_BITS-1:0]    texel_index,
	output logic                                     degenerate
);

	localparam int FW  = WB + 3;
	localparam int PW  = FW + WB;
	localparam int TIW = cmta_pkg::TEXEL_INDEX_BITS;
	localparam int SW  = (PW > TIW) ? PW : TIW;

	logic [WB-1:0]  wm1, col_cl, row_cl;
	cmta_pkg::face_t face_d;

	logic [CW-1:0]   col_s1, row_s1;
	logic [FW-1:0]   facew_s1;
	cmta_pkg::face_t face_s1;
	logic            degen_s1;

	logic [CW-1:0]   col_s2, row_s2;
	logic [FW-1:0]   base_s2;
	cmta_pkg::face_t face_s2;
	logic            degen_s2;

	logic [CW-1:0]   col_s3, row_s3;
	logic [PW-1:0]   prod_s3;
	cmta_pkg::face_t face_s3;
	logic            degen_s3;

	logic [CW-1:0]   col_s4, row_s4;
	logic [TIW-1:0]  idx_s4;
	cmta_pkg::face_t face_s4;
	logic            degen_s4;
	logic [SW-1:0]   idx_sum;

	assign wm1 = w - 1'b1;

	// clamp the quotients to w - 1; a zero vector drops everything to face 0, texel 0
	always_comb begin
		col_cl = (quo_col > wm1) ? wm1 : quo_col;
		row_cl = (quo_row > wm1) ? wm1 : quo_row;
		face_d = info.face;
		if (info.degen) begin
			col_cl = '0;
			row_cl = '0;
			face_d = cmta_pkg::FACE_POS_X;
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			col_s1   <= CW'(col_cl);
			row_s1   <= CW'(row_cl);
			facew_s1 <= FW'(face_d) * FW'(w);
			face_s1  <= face_d;
			degen_s1 <= info.degen;
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			col_s2   <= col_s1;
			row_s2   <= row_s1;
			base_s2  <= facew_s1 + FW'(row_s1);
			face_s2  <= face_s1;
			degen_s2 <= degen_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			col_s3   <= col_s2;
			row_s3   <= row_s2;
			prod_s3  <= PW'(base_s2) * PW'(w);
			face_s3  <= face_s2;
			degen_s3 <= degen_s2;
		end
	end

	assign idx_sum = SW'(prod_s3) + SW'(col_s3);

	always_ff @(posedge clk) begin
		if (en[3]) begin
			col_s4   <= col_s3;
			row_s4   <= row_s3;
			idx_s4   <= idx_sum[TIW-1:0];
			face_s4  <= face_s3;
			degen_s4 <= degen_s3;
		end
	end

	assign face        = face_s4;
	assign col         = col_s4;
	assign row         = row_s4;
	assign texel_index = idx_s4;
	assign degenerate  = degen_s4;

endmodule

@@ rtl/cube_map_texel_address.sv @@
// Top level of the cube map face selection and texel addressing pipeline.
// Depends on cmta_pkg, cmta_face_sel, cmta_div and cmta_addr.
//
//   channel   valid      stall      payload
//   -------   --------   --------   -----------------------------------------
//   input     in_valid   in_stall   dir_x, dir_y, dir_z
//   output    out_valid  out_stall  face, col, row, texel_index, degenerate
//   config    cfg_wr_en  (none)     cfg_wr_data -> face_width
//
// Throughput is one beat per clock while out_stall is low. WB =
// clog2(MAX_FACE_WIDTH + 1) is the number of quotient bits: the two
// restoring divider lanes retire one bit per stage.
// Reset clears the valid bits and loads face_width with 1024; data registers
// are not reset. A stalled output holds its beat while empty stages upstream
// keep filling, so bubbles are squeezed out before the input is stalled.
module cube_map_texel_address #(
	parameter int MAX_FACE_WIDTH = cmta_pkg::MAX_FACE_WIDTH_DEF,
	parameter int COMPONENT_BITS = cmta_pkg::COMPONENT_BITS_DEF,
	localparam int CW = (MAX_FACE_WIDTH > 1) ? $clog2(MAX_FACE_WIDTH) : 1
) (
	input  logic                                    clk,
	input  logic                                    arst_n,

	input  logic                                    cfg_wr_en,
	input  logic [cmta_pkg::FACE_WIDTH_BITS-1:0]    cfg_wr_data,

	input  logic                                    in_valid,
	output logic                                    in_stall,
	input  logic signed [COMPONENT_BITS-1:0]        dir_x,
	input  logic signed [COMPONENT_BITS-1:0]        dir_y,
	input  logic signed [COMPONENT_BITS-1:0]        dir_z,

	output logic                                    out_valid,
	input  logic                                    out_stall,
	output logic [cmta_pkg::FACE_BITS-1:0]          face,
	output logic [CW-1:0]                           col,
	output logic [CW-1:0]                           row,
	output logic [cmta_pkg::TEXEL_INDEX_BITS-1:0]   texel_index,
	output logic                                    degenerate
);

	localparam int CB   = COMPONENT_BITS;
	localparam int WB   = $clog2(MAX_FACE_WIDTH + 1);
	localparam int FS   = cmta_pkg::FRONT_STAGES;
	localparam int BS   = cmta_pkg::BACK_STAGES;
	localparam int N    = FS + WB + BS;
	localparam int RW   = CB + 1 + WB;
	localparam int CMPW = (WB > cmta_pkg::FACE_WIDTH_BITS) ? WB : cmta_pkg::FACE_WIDTH_BITS;

	// face_width register and its saturated form
	logic [cmta_pkg::FACE_WIDTH_BITS-1:0] face_width_q;
	logic [CMPW-1:0]                      fw_ext;
	logic [WB-1:0]                        w_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			face_width_q <= cmta_pkg::FACE_WIDTH_RESET;
		end else if (cfg_wr_en) begin
			face_width_q <= cfg_wr_data;
		end
	end

	// Config changes only while the pipe is idle (the user's duty; the block does
	// not enforce it), as every stage reads the live value.
	assign fw_ext = CMPW'(face_width_q);

	always_comb begin
		priority if (fw_ext == '0) begin
			w_eff = WB'(1);
		end else if (fw_ext > CMPW'(MAX_FACE_WIDTH)) begin
			w_eff = WB'(MAX_FACE_WIDTH);
		end else begin
			w_eff = WB'(fw_ext);
		end
	end

	// Pipeline control: a stage may load when it, or any stage after it,
	// is empty, or when the output is being drained.
	logic [N-1:0] vld_s;
	logic [N-1:0] vld_in;
	logic [N-1:0] en;

	// valid bit offered to each stage: the input for the first, the stage before it after that
	assign vld_in = {vld_s[N-2:0], in_valid};

	for (genvar i = 0; i < N; i++) begin : g_ctl
		assign en[i] = !out_stall || !(&vld_s[N-1:i]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en[i]) begin
				vld_s[i] <= vld_in[i];
			end
		end
	end

	assign in_stall  = !en[0];
	assign out_valid = vld_s[N-1];

	// Front: face pick and division operands
	logic [RW-1:0]        num_col, num_row;
	logic [CB:0]          den;
	cmta_pkg::face_info_t info_f;

	cmta_face_sel #(
		.CB (CB),
		.WB (WB)
	) u_face_sel (
		.clk     (clk),
		.en      (en[FS-1:0]),
		.dir_x   (dir_x),
		.dir_y   (dir_y),
		.dir_z   (dir_z),
		.w       (w_eff),
		.num_col (num_col),
		.num_row (num_row),
		.den     (den),
		.info    (info_f)
	);

	// Two divider lanes, one per face coordinate
	logic [WB-1:0] quo_col, quo_row;

	cmta_div #(
		.CB (CB),
		.QB (WB)
	) u_div_col (
		.clk (clk),
		.en  (en[FS+WB-1:FS]),
		.num (num_col),
		.den (den),
		.quo (quo_col)
	);

	cmta_div #(
		.CB (CB),
		.QB (WB)
	) u_div_row (
		.clk (clk),
		.en  (en[FS+WB-1:FS]),
		.num (num_row),
		.den (den),
		.quo (quo_row)
	);

	// Carry face and degenerate flag alongside the divider lanes
	cmta_pkg::face_info_t info_sd [WB];

	for (genvar i = 0; i < WB; i++) begin : g_info
		if (i == 0) begin : g_head
			always_ff @(posedge clk) begin
				if (en[FS]) begin
					info_sd[i] <= info_f;
				end
			end
		end else begin : g_tail
			always_ff @(posedge clk) begin
				if (en[FS+i]) begin
					info_sd[i] <= info_sd[i-1];
				end
			end
		end
	end

	// Back: clamp, address, output register
	cmta_addr #(
		.WB (WB),
		.CW (CW)
	) u_addr (
		.clk         (clk),
		.en          (en[N-1:N-BS]),
		.w           (w_eff),
		.quo_col     (quo_col),
		.quo_row     (quo_row),
		.info        (info_sd[WB-1]),
		.face        (face),
		.col         (col),
		.row         (row),
		.texel_index (texel_index),
		.degenerate  (degenerate)
	);

endmodule

@@ dv/cube_map_texel_address_test.sv @@
// Self-checking testbench for cube_map_texel_address: face selection, texel column, row and index, degenerate flag.
// Depends on cmta_pkg and the RTL top level. A built-in address predictor checks every
// output beat in order while the face width setting, idling and back-pressure vary.
module cube_map_texel_address_test;
	timeunit 1ns;
	timeprecision 1ps;

	import cmta_pkg::*;

	localparam int COMP_BITS  = COMPONENT_BITS_DEF;
	localparam int COORD_BITS = $clog2(MAX_FACE_WIDTH_DEF);
	// pipeline depth: front stages, one divider stage per quotient bit, back stages
	localparam int PIPE_DEPTH = FRONT_STAGES + $clog2(MAX_FACE_WIDTH_DEF + 1) + BACK_STAGES;
	localparam int QUIET_LIMIT      = 1000;
	localparam int BEATS_PER_PHASE  = 100;
	localparam int PHASE_COUNT      = 8;
	localparam int LONG_HOLD_CYCLES = 120;

	typedef struct {
		face_t                          face;
		logic [COORD_BITS-1:0]          col;
		logic [COORD_BITS-1:0]          row;
		logic [TEXEL_INDEX_BITS-1:0]    index;
		logic                           degen;
	} texel_t;

	// Expected texel addresses, oldest first, plus the face width they were computed with.
	class texel_address_tracker;
		texel_t                      pending_texels[$];
		logic [FACE_WIDTH_BITS-1:0]  face_width;
		int                          errors;

		function new();
			face_width = FACE_WIDTH_RESET;
			errors = 0;
		endfunction

		function void set_face_width(logic [FACE_WIDTH_BITS-1:0] w);
			face_width = w;
		endfunction

		function int pending();
			return pending_texels.size();
		endfunction

		// floor((c + ma) * w / (2 * ma)), clamped to the last texel
		function longint edge_coord(longint c, longint ma, longint w);
			longint q;
			q = (c + ma) * w / (2 * ma);
			return (q > w - 1) ? w - 1 : q;
		endfunction

		function texel_t address_of(logic signed [COMP_BITS-1:0] x,
				logic signed [COMP_BITS-1:0] y, logic signed [COMP_BITS-1:0] z);
			longint sx, sy, sz, ax, ay, az, sc, tc, ma, w, c, r, idx;
			texel_t t;
			sx = x;
			sy = y;
			sz = z;
			ax = (sx < 0) ? -sx : sx;
			ay = (sy < 0) ? -sy : sy;
			az = (sz < 0) ? -sz : sz;
			w = face_width;
			if (w < 1)
				w = 1;
			if (w > MAX_FACE_WIDTH_DEF)
				w = MAX_FACE_WIDTH_DEF;
			if (ax == 0 && ay == 0 && az == 0) begin
				t.face = FACE_POS_X;
				t.col = '0;
				t.row = '0;
				t.index = '0;
				t.degen = 1'b1;
				return t;
			end
			if (ax >= ay && ax >= az) begin
				tc = -sy;
				ma = ax;
				if (sx >= 0) begin
					sc = -sz;
					t.face = FACE_POS_X;
				end else begin
					sc = sz;
					t.face = FACE_NEG_X;
				end
			end else if (ay >= az) begin
				sc = sx;
				ma = ay;
				if (sy >= 0) begin
					tc = sz;
					t.face = FACE_POS_Y;
				end else begin
					tc = -sz;
					t.face = FACE_NEG_Y;
				end
			end else begin
				tc = -sy;
				ma = az;
				if (sz >= 0) begin
					sc = sx;
					t.face = FACE_POS_Z;
				end else begin
					sc = -sx;
					t.face = FACE_NEG_Z;
				end
			end
			c = edge_coord(sc, ma, w);
			r = edge_coord(tc, ma, w);
			idx = (longint'(t.face) * w + r) * w + c;
			t.col = c[COORD_BITS-1:0];
			t.row = r[COORD_BITS-1:0];
			t.index = idx[TEXEL_INDEX_BITS-1:0];
			t.degen = 1'b0;
			return t;
		endfunction

		function void note_direction(logic signed [COMP_BITS-1:0] x,
				logic signed [COMP_BITS-1:0] y, logic signed [COMP_BITS-1:0] z);
			pending_texels.insert(pending_texels.size(), address_of(x, y, z));
		endfunction

		function void compare_field(string name, logic [TEXEL_INDEX_BITS-1:0] want,
				logic [TEXEL_INDEX_BITS-1:0] got);
			if (want !== got) begin
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_texel(logic [FACE_BITS-1:0] face, logic [COORD_BITS-1:0] col,
				logic [COORD_BITS-1:0] row, logic [TEXEL_INDEX_BITS-1:0] index,
				logic degen);
			texel_t t;
			if (pending_texels.size() == 0) begin
				$display("%0t: unexpected beat, face %0d col %0d row %0d index %0d degenerate %0d",
					$time, face, col, row, index, degen);
				errors++;
				return;
			end
			t = pending_texels.pop_front();
			compare_field("face", t.face, face);
			compare_field("col", t.col, col);
			compare_field("row", t.row, row);
			compare_field("texel_index", t.index, index);
			compare_field("degenerate", t.degen, degen);
		endfunction
	endclass

	bit                               clk = 1'b0;
	logic                             arst_n;
	logic                             cfg_wr_en;
	logic [FACE_WIDTH_BITS-1:0]       cfg_wr_data;
	logic                             in_valid;
	logic                             in_stall;
	logic signed [COMP_BITS-1:0]      dir_x;
	logic signed [COMP_BITS-1:0]      dir_y;
	logic signed [COMP_BITS-1:0]      dir_z;
	logic                             out_valid;
	logic                             out_stall;
	logic [FACE_BITS-1:0]             face;
	logic [COORD_BITS-1:0]            col;
	logic [COORD_BITS-1:0]            row;
	logic [TEXEL_INDEX_BITS-1:0]      texel_index;
	logic                             degenerate;

	texel_address_tracker tracker;

	// idling percentages for the current phase, and the request for one long output hold
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	bit          long_hold_request;
	int          quiet_cycles;

	cube_map_texel_address dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.dir_x       (dir_x),
		.dir_y       (dir_y),
		.dir_z       (dir_z),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.face        (face),
		.col         (col),
		.row         (row),
		.texel_index (texel_index),
		.degenerate  (degenerate)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Offer one direction beat, after a random gap, and hold it until the block takes it.
	// Returns in the time step of the accepting edge, so the next beat can follow at once.
	task automatic send_direction(input logic signed [COMP_BITS-1:0] x,
			input logic signed [COMP_BITS-1:0] y, input logic signed [COMP_BITS-1:0] z);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		dir_x <= x;
		dir_y <= y;
		dir_z <= z;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		tracker.note_direction(x, y, z);
	endtask

	function automatic logic signed [COMP_BITS-1:0] extreme_component();
		case ($urandom_range(5))
			0: return -32768;
			1: return -32767;
			2: return -1;
			3: return 0;
			4: return 1;
			default: return 32767;
		endcase
	endfunction

	// Mix of full-range vectors, tiny vectors, extremes, magnitude ties and zero or
	// single-axis vectors; ties and tiny values are where face choice and clamping bite.
	task automatic send_random_direction();
		int unsigned kind;
		logic signed [COMP_BITS-1:0] a, b, c, x, y, z;
		kind = $urandom_range(9);
		a = $urandom;
		b = $urandom;
		c = $urandom;
		case (kind)
			5, 6: begin
				a = $urandom_range(8) - 4;
				b = $urandom_range(8) - 4;
				c = $urandom_range(8) - 4;
			end
			7: begin
				a = extreme_component();
				b = extreme_component();
				c = extreme_component();
			end
			8: begin
				b = $urandom_range(1) ? a : -a;
				if ($urandom_range(1))
					c = $urandom_range(1) ? a : -a;
			end
			9: begin
				a = $urandom_range(1) ? a : '0;
				b = '0;
				c = '0;
			end
			default: ;
		endcase
		// rotate so that every axis gets the tie and single-axis cases
		case ($urandom_range(2))
			0: begin x = a; y = b; z = c; end
			1: begin x = c; y = a; z = b; end
			default: begin x = b; y = c; z = a; end
		endcase
		send_direction(x, y, z);
	endtask

	// Write the face width only once the pipeline has drained; every beat gives a result,
	// so an empty expectation queue means the block is idle.
	task automatic write_face_width(input logic [FACE_WIDTH_BITS-1:0] w);
		while (tracker.pending() != 0)
			@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= w;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		tracker.set_face_width(w);
	endtask

	// Output side: check the beat taken at this edge, then pick the stall for the next one.
	initial begin
		int hold_left;
		hold_left = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_stall === 1'b0)
				tracker.check_texel(face, col, row, texel_index, degenerate);
			if (long_hold_request) begin
				hold_left = LONG_HOLD_CYCLES;
				long_hold_request = 1'b0;
			end
			if (hold_left > 0) begin
				// hold off long enough for the pipeline to fill and stall its input
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	// Watchdog: end the run if neither side moves a beat for too long.
	always @(posedge clk) begin
		if (arst_n !== 1'b1 || (in_valid === 1'b1 && in_stall === 1'b0)
				|| (out_valid === 1'b1 && out_stall === 1'b0)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	initial begin
		logic [FACE_WIDTH_BITS-1:0] width_plan[PHASE_COUNT];
		tracker = new();
		quiet_cycles = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		long_hold_request = 1'b0;
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= '0;
		in_valid <= 1'b0;
		dir_x <= '0;
		dir_y <= '0;
		dir_z <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed beats at the reset width of 1024.
		send_direction(0, 0, 0);                  // zero vector: degenerate
		send_direction(32767, 0, 0);              // one per face, largest magnitudes
		send_direction(-32768, 0, 0);
		send_direction(0, 32767, 0);
		send_direction(0, -32768, 0);
		send_direction(0, 0, 32767);
		send_direction(0, 0, -32768);
		send_direction(100, 100, 100);            // three-way tie: X wins
		send_direction(-100, 100, -100);
		send_direction(5, 7, 7);                  // Y and Z tie: Y wins
		send_direction(3, -9, 9);
		send_direction(32767, 32767, -32768);     // Z wins by one
		send_direction(-32768, -32768, -32768);   // coordinate lands on the face edge
		send_direction(32767, -32768, -32768);    // Y over Z at the negative extreme
		send_direction(1, -1, 1);                 // unit magnitudes, row clamps
		send_direction(-1, 0, 0);
		send_direction(1, 0, 0);
		send_direction(0, 1, 0);
		send_direction(0, 0, -1);
		send_direction(-1, -1, -1);
		send_direction(16'sh5555, 16'shAAAA, 16'sh2AAA);
		in_valid <= 1'b0;

		// Widths: extremes, values outside the range that saturate, odd sizes, one random.
		width_plan[0] = 11'd1;
		width_plan[1] = 11'd0;
		width_plan[2] = 11'd2047;
		width_plan[3] = 11'd1024;
		width_plan[4] = 11'd3;
		width_plan[5] = 11'd1023;
		width_plan[6] = 11'd640;
		width_plan[7] = $urandom_range(1024, 2);

		for (int p = 0; p < PHASE_COUNT; p++) begin
			write_face_width(width_plan[p]);
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
				default: begin send_idle_pct = 29; recv_stall_pct = 29; end
			endcase
			// sender never idles in this phase, so the long hold backs up to the input
			if (p == 4)
				long_hold_request = 1'b1;
			repeat (BEATS_PER_PHASE)
				send_random_direction();
			in_valid <= 1'b0;
		end

		// Drain, then give the pipeline time to show any extra beat.
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (2 * PIPE_DEPTH) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
